@@ hdl/s512_pkg.sv @@
// Shared types, constants and functions of the SHA-512 hash engine.
package s512_pkg;

	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS      = 80;
	localparam int unsigned PAD_LIMIT   = 112;
	localparam logic [7:0]  PAD_MARK    = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RND,
		ST_FOLD,
		ST_EMIT
	} s512_state_t;

	// Which block the current compression works on
	typedef enum logic [1:0] {
		PH_DATA,
		PH_PAD1,
		PH_PAD2
	} s512_phase_t;

	// Commands from the sequencer to the round unit
	typedef struct packed {
		logic init;   // reload initial hash values
		logic start;  // working vars take the chaining words
		logic step;   // one round
		logic fold;   // chaining words += working vars
	} s512_rctl_t;

	localparam logic [63:0] IV_TBL [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [63:0] K_TBL [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] ssig0(input logic [63:0] x);
		ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic logic [63:0] ssig1(input logic [63:0] x);
		ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic logic [63:0] bsig0(input logic [63:0] x);
		bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic logic [63:0] bsig1(input logic [63:0] x);
		bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

endpackage

@@ hdl/sha512_hash_engine_top.sv @@
// Top level of the streaming SHA-512 engine: block memory, sequencer, output.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | msg_byte, byte_valid, finish
//  out     | out_valid/out_stall| digest_word, word_index, last_word
//
// A byte request that fills a block starts a compression: the block memory is streamed
// into the schedule window, 80 rounds run, then one fold.
// Finish adds one or two such compressions (two when 112 or more bytes are pending),
// then eight digest words leave one per cycle while out_stall is low.
// Reset restores the initial hash values and clears byte and bit counts.
// in_stall is high whenever a compression or the digest output is in progress.
module sha512_hash_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  msg_byte,
	input  logic        byte_valid,
	input  logic        finish,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import s512_pkg::*;

	s512_state_t      state_q, state_d;
	s512_phase_t      phase_q;
	logic             fin_pend_q;
	logic [6:0]       fill_q;
	logic [63:0]      bits_q;
	logic [63:0]      asm_q;
	logic [63:0]      asm_d;
	logic [6:0]       cnt_q;
	logic [2:0]       eidx_q;
	logic [63:0]      mem [16];
	logic [63:0]      rdata_q;
	logic             in_acc;
	logic             out_acc;
	logic             mem_we;
	logic [3:0]       ld_idx;
	logic [63:0]      pad_word;
	logic [63:0]      ld_word;
	logic             push;
	logic [63:0]      w_cur;
	logic [7:0][63:0] chain;
	s512_rctl_t       rctl;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// byte placed into the partial word at its big-endian lane
	always_comb begin
		asm_d = asm_q;
		for (int b = 0; b < 8; b++)
			if (fill_q[2:0] == 3'(b)) asm_d[63-8*b -: 8] = msg_byte;
	end
	assign mem_we = in_acc && byte_valid && (fill_q[2:0] == 3'd7);

	// block memory, one word written per eight bytes, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[fill_q[6:3]] <= asm_d;
		rdata_q <= mem[cnt_q[3:0]];
	end

	// word holding the end mark: kept bytes, 0x80, zeros
	always_comb begin
		pad_word = '0;
		for (int b = 0; b < 8; b++) begin
			if (fill_q[2:0] > 3'(b)) pad_word[63-8*b -: 8] = asm_q[63-8*b -: 8];
			else if (fill_q[2:0] == 3'(b)) pad_word[63-8*b -: 8] = PAD_MARK;
		end
	end

	// word pushed into the schedule during load
	assign ld_idx = 4'(cnt_q - 7'd1);
	always_comb begin
		ld_word = rdata_q;
		unique case (phase_q)
			PH_DATA: ld_word = rdata_q;
			PH_PAD1: begin
				if (ld_idx == fill_q[6:3]) ld_word = pad_word;
				else if (ld_idx > fill_q[6:3]) ld_word = '0;
				if (fill_q < 7'(PAD_LIMIT) && ld_idx == 4'd15) ld_word = bits_q;
			end
			PH_PAD2: ld_word = (ld_idx == 4'd15) ? bits_q : '0;
			default: ld_word = rdata_q;
		endcase
	end
	assign push = (state_q == ST_LOAD) && (cnt_q != 7'd0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc && ((byte_valid && fill_q == 7'd127) || finish)) state_d = ST_LOAD;
			ST_LOAD: if (cnt_q == 7'(BLOCK_WORDS)) state_d = ST_RND;
			ST_RND:  if (cnt_q == 7'(ROUNDS - 1)) state_d = ST_FOLD;
			ST_FOLD: begin
				unique case (phase_q)
					PH_DATA: state_d = fin_pend_q ? ST_LOAD : ST_IDLE;
					PH_PAD1: state_d = (fill_q >= 7'(PAD_LIMIT)) ? ST_LOAD : ST_EMIT;
					PH_PAD2: state_d = ST_EMIT;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_EMIT: if (out_acc && eidx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		out_valid  = (state_q == ST_EMIT);
		rctl.init  = (state_q == ST_EMIT) && out_acc && eidx_q == 3'd7;
		rctl.start = (state_q == ST_LOAD) && cnt_q == 7'(BLOCK_WORDS);
		rctl.step  = (state_q == ST_RND);
		rctl.fold  = (state_q == ST_FOLD);
	end

	// state, counters and message bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_DATA;
			fin_pend_q <= 1'b0;
			fill_q     <= '0;
			bits_q     <= '0;
			cnt_q      <= '0;
			eidx_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						if (byte_valid) begin
							fill_q <= fill_q + 7'd1;
							bits_q <= bits_q + 64'd8;
						end
						if (byte_valid && fill_q == 7'd127) begin
							phase_q    <= PH_DATA;
							fin_pend_q <= finish;
						end else begin
							phase_q <= PH_PAD1;
						end
					end
				end
				ST_LOAD: cnt_q <= (cnt_q == 7'(BLOCK_WORDS)) ? '0 : cnt_q + 7'd1;
				ST_RND:  cnt_q <= cnt_q + 7'd1;
				ST_FOLD: begin
					cnt_q <= '0;
					if (phase_q == PH_DATA) begin
						phase_q    <= PH_PAD1;
						fin_pend_q <= 1'b0;
					end else if (phase_q == PH_PAD1) begin
						phase_q <= PH_PAD2;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						eidx_q <= eidx_q + 3'd1;
						if (eidx_q == 3'd7) begin
							fill_q <= '0;
							bits_q <= '0;
						end
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	// partial word assembly
	always_ff @(posedge clk) begin
		if (in_acc && byte_valid) asm_q <= asm_d;
	end

	s512_sched u_sched (
		.clk       (clk),
		.push      (push),
		.push_word (ld_word),
		.step      (rctl.step),
		.w_cur     (w_cur)
	);

	s512_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rctl),
		.k_cur  (K_TBL[cnt_q]),
		.w_cur  (w_cur),
		.chain  (chain)
	);

	assign digest_word = chain[eidx_q];
	assign word_index  = eidx_q;
	assign last_word   = (eidx_q == 3'd7);

	a_load_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> cnt_q <= 7'(BLOCK_WORDS))
		else $error("load counter overrun");
	a_rnd_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RND |-> cnt_q < 7'(ROUNDS))
		else $error("round counter overrun");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last_word |=> fill_q == 7'd0 && bits_q == 64'd0)
		else $error("message state not cleared after digest");
	a_pad2: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD && phase_q == PH_PAD2 |-> fill_q >= 7'(PAD_LIMIT))
		else $error("extra pad block without need");

endmodule

@@ hdl/s512_sched.sv @@
// Rolling 16-word message schedule window.
module s512_sched (
	input  logic        clk,
	input  logic        push,
	input  logic [63:0] push_word,
	input  logic        step,
	output logic [63:0] w_cur
);
	import s512_pkg::*;

	logic [63:0] win_q [16];
	logic [63:0] w_next;

	// next schedule word from the taps
	assign w_next = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
	assign w_cur  = win_q[0];

	// shift in loaded words or computed words
	always_ff @(posedge clk) begin
		if (push || step) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= push ? push_word : w_next;
		end
	end

endmodule

@@ hdl/s512_round.sv @@
// Working variables, chaining words and the SHA-512 round function.
module s512_round (
	input  logic                    clk,
	input  logic                    arst_n,
	input  s512_pkg::s512_rctl_t    ctl,
	input  logic [63:0]             k_cur,
	input  logic [63:0]             w_cur,
	output logic [7:0][63:0]        chain
);
	import s512_pkg::*;

	logic [7:0][63:0] chain_q;
	logic [7:0][63:0] v_q;
	logic [63:0]      t1;
	logic [63:0]      t2;

	// round terms
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ k_cur + w_cur;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign chain = chain_q;

	// chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= IV_TBL[i];
		end else if (ctl.init) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= IV_TBL[i];
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			v_q <= chain_q;
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule
